FILE: rtl/gba3d_pkg.sv
// Shared types and constants of the 3D first-fit box allocator.
// No dependencies; used by grid_box_allocator_3d_top.
package gba3d_pkg;

    localparam int MAX_X = 16;
    localparam int MAX_Y = 16;
    localparam int MAX_Z = 8;

    localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int RW    = YW + ZW;           // occupancy row address {z, y}
    localparam int CW    = RW + XW;           // cell address {z, y, x}
    localparam int CELLS = 1 << CW;

    // field widths fixed by the interface
    localparam int SXW   = 5;
    localparam int SYW   = 5;
    localparam int SZW   = 4;
    localparam int AXW   = 4;
    localparam int AYW   = 4;
    localparam int AZW   = 3;
    localparam int STW   = 2;
    localparam int RECW  = 1 + SXW + SYW + SZW;

    localparam logic [1:0] CFG_AREA_X = 2'd0;
    localparam logic [1:0] CFG_AREA_Y = 2'd1;
    localparam logic [1:0] CFG_AREA_Z = 2'd2;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [STW-1:0] {
        ST_DONE    = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_NOT_REG = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_AEVAL,
        S_RCHK,
        S_MARK,
        S_MFIN,
        S_DONE
    } t_state;

endpackage

FILE: rtl/grid_box_allocator_3d_top.sv
// Top level of the 3D first-fit box allocator: occupancy row memory, record memory
// and the search / mark sequencer. Depends on gba3d_pkg.
//
//  channel   | group               | content
//  ----------+---------------------+---------------------------------------------
//  request   | s_axis_t*           | tuser cmd; tdata size x/y/z, release origin
//  result    | m_axis_t*           | tuser status; tdata place x/y/z
//  config    | i_cfg_we/idx/data   | area_x, area_y, area_z
//
// Reset clears both memories in one pass over all CELLS (2048) cell addresses; no
// request is taken until it ends. Allocate reads the box rows at each tried origin
// row, then marks them; the single read port of the occupancy memory, one row a
// cycle, sets the pace. Release reads its record and marks. A result waits in the
// output register; while it waits the next request runs up to its result and holds.
module grid_box_allocator_3d_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // size_x[4:0] size_y[9:5] size_z[13:10]
                                       // at_x[17:14] at_y[21:18] at_z[24:22]
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // place_x[3:0] place_y[7:4] place_z[10:8]
    output logic [1:0]  m_axis_tuser   // status
);

    // request fields
    logic [gba3d_pkg::SXW-1:0] w_sx;
    logic [gba3d_pkg::SYW-1:0] w_sy;
    logic [gba3d_pkg::SZW-1:0] w_sz;
    logic [gba3d_pkg::AXW-1:0] w_atx;
    logic [gba3d_pkg::AYW-1:0] w_aty;
    logic [gba3d_pkg::AZW-1:0] w_atz;
    assign w_sx  = s_axis_tdata[4:0];
    assign w_sy  = s_axis_tdata[9:5];
    assign w_sz  = s_axis_tdata[13:10];
    assign w_atx = s_axis_tdata[17:14];
    assign w_aty = s_axis_tdata[21:18];
    assign w_atz = s_axis_tdata[24:22];

    // config
    logic [4:0] r_area_x, r_area_y;
    logic [3:0] r_area_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_x <= 5'd16;
            r_area_y <= 5'd16;
            r_area_z <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gba3d_pkg::CFG_AREA_X: r_area_x <= i_cfg_data;
                gba3d_pkg::CFG_AREA_Y: r_area_y <= i_cfg_data;
                gba3d_pkg::CFG_AREA_Z: r_area_z <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [gba3d_pkg::MAX_X-1:0] occ_mem [gba3d_pkg::MAX_Y*gba3d_pkg::MAX_Z];
    logic [gba3d_pkg::RECW-1:0]  rec_mem [gba3d_pkg::CELLS];

    logic                         occ_we;
    logic [gba3d_pkg::RW-1:0]     occ_waddr, occ_raddr;
    logic [gba3d_pkg::MAX_X-1:0]  occ_wdata, r_occ_q;
    logic                         rec_we;
    logic [gba3d_pkg::CW-1:0]     rec_waddr, rec_raddr;
    logic [gba3d_pkg::RECW-1:0]   rec_wdata, r_rec_q;

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        r_occ_q <= occ_mem[occ_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        r_rec_q <= rec_mem[rec_raddr];
    end

    // sequencer registers
    gba3d_pkg::t_state r_state, n_state;
    logic [gba3d_pkg::CW-1:0]    r_clr, n_clr;
    logic [gba3d_pkg::SXW-1:0]   r_sx, n_sx;
    logic [gba3d_pkg::SYW-1:0]   r_sy, n_sy;
    logic [gba3d_pkg::SZW-1:0]   r_sz, n_sz;
    logic [4:0]                  r_ax, n_ax, r_ay, n_ay;
    logic [3:0]                  r_az, n_az;
    logic [gba3d_pkg::XW-1:0]    r_px, n_px;
    logic [gba3d_pkg::YW-1:0]    r_y0, n_y0, r_j, n_j;
    logic [gba3d_pkg::ZW-1:0]    r_z0, n_z0, r_k, n_k;
    logic [gba3d_pkg::MAX_X-1:0] r_acc, n_acc;
    logic                        r_rd_vld, n_rd_vld;
    logic [gba3d_pkg::RW-1:0]    r_rd_row, n_rd_row;
    logic                        r_set, n_set;
    gba3d_pkg::t_status          r_res_st, n_res_st;
    logic [gba3d_pkg::XW-1:0]    r_res_x, n_res_x;
    logic [gba3d_pkg::YW-1:0]    r_res_y, n_res_y;
    logic [gba3d_pkg::ZW-1:0]    r_res_z, n_res_z;
    logic                        r_out_vld, n_out_vld;
    gba3d_pkg::t_status          r_out_st, n_out_st;
    logic [gba3d_pkg::XW-1:0]    r_out_x, n_out_x;
    logic [gba3d_pkg::YW-1:0]    r_out_y, n_out_y;
    logic [gba3d_pkg::ZW-1:0]    r_out_z, n_out_z;

    // shared decode
    logic                        w_acc_in;
    logic                        w_last;
    logic [gba3d_pkg::RW-1:0]    w_row;
    logic [4:0]                  w_cax, w_cay;
    logic [3:0]                  w_caz;
    logic                        w_bad;
    logic                        w_rel_oor;
    logic [gba3d_pkg::MAX_X-1:0] w_mask, w_win;
    logic                        w_found;
    logic [gba3d_pkg::XW-1:0]    w_fx;
    logic                        w_y_adv, w_z_adv;
    logic                        w_out_free;

    assign s_axis_tready = (r_state == gba3d_pkg::S_IDLE);
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    assign w_last = ({1'b0, r_j} == (gba3d_pkg::YW+1)'(r_sy - 5'd1)) &&
                    ({1'b0, r_k} == (gba3d_pkg::ZW+1)'(r_sz - 4'd1));
    assign w_row  = {gba3d_pkg::ZW'(r_z0 + r_k), gba3d_pkg::YW'(r_y0 + r_j)};

    assign w_cax = (r_area_x > 5'(gba3d_pkg::MAX_X)) ? 5'(gba3d_pkg::MAX_X) : r_area_x;
    assign w_cay = (r_area_y > 5'(gba3d_pkg::MAX_Y)) ? 5'(gba3d_pkg::MAX_Y) : r_area_y;
    assign w_caz = (r_area_z > 4'(gba3d_pkg::MAX_Z)) ? 4'(gba3d_pkg::MAX_Z) : r_area_z;
    assign w_bad = (w_sx == '0) || (w_sy == '0) || (w_sz == '0) ||
                   (w_sx > w_cax) || (w_sy > w_cay) || (w_sz > w_caz);
    assign w_rel_oor = (32'(w_atx) >= gba3d_pkg::MAX_X) ||
                       (32'(w_aty) >= gba3d_pkg::MAX_Y) ||
                       (32'(w_atz) >= gba3d_pkg::MAX_Z);

    assign w_mask = r_acc | r_occ_q;
    assign w_win  = gba3d_pkg::MAX_X'(((
                        (2*gba3d_pkg::MAX_X)'(1) << r_sx) - (2*gba3d_pkg::MAX_X)'(1))
                        << r_px);

    // lowest x whose window is free and inside the area
    always_comb begin
        logic [2*gba3d_pkg::MAX_X-1:0] win;
        w_found = 1'b0;
        w_fx    = '0;
        for (int i = gba3d_pkg::MAX_X - 1; i >= 0; i--) begin
            win = (((2*gba3d_pkg::MAX_X)'(1) << r_sx) - (2*gba3d_pkg::MAX_X)'(1)) << i;
            if ((6'(i) + 6'(r_sx) <= 6'(r_ax)) &&
                ((w_mask & gba3d_pkg::MAX_X'(win)) == '0)) begin
                w_found = 1'b1;
                w_fx    = gba3d_pkg::XW'(i);
            end
        end
    end

    assign w_y_adv = (6'(r_y0) + 6'd1 + 6'(r_sy) <= 6'(r_ay));
    assign w_z_adv = (6'(r_z0) + 6'd1 + 6'(r_sz) <= 6'(r_az));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gba3d_pkg::S_CLEAR: begin
                if (r_clr == gba3d_pkg::CW'(gba3d_pkg::CELLS - 1)) n_state = gba3d_pkg::S_IDLE;
            end
            gba3d_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    if (s_axis_tuser == gba3d_pkg::CMD_RELEASE) begin
                        n_state = w_rel_oor ? gba3d_pkg::S_DONE : gba3d_pkg::S_RCHK;
                    end else begin
                        n_state = w_bad ? gba3d_pkg::S_DONE : gba3d_pkg::S_ASCAN;
                    end
                end
            end
            gba3d_pkg::S_ASCAN: begin
                if (w_last) n_state = gba3d_pkg::S_AEVAL;
            end
            gba3d_pkg::S_AEVAL: begin
                if (w_found) n_state = gba3d_pkg::S_MARK;
                else if (w_y_adv || w_z_adv) n_state = gba3d_pkg::S_ASCAN;
                else n_state = gba3d_pkg::S_DONE;
            end
            gba3d_pkg::S_RCHK: begin
                n_state = r_rec_q[gba3d_pkg::RECW-1] ? gba3d_pkg::S_MARK : gba3d_pkg::S_DONE;
            end
            gba3d_pkg::S_MARK: begin
                if (w_last) n_state = gba3d_pkg::S_MFIN;
            end
            gba3d_pkg::S_MFIN: n_state = gba3d_pkg::S_DONE;
            gba3d_pkg::S_DONE: begin
                if (w_out_free) n_state = gba3d_pkg::S_IDLE;
            end
            default: n_state = gba3d_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_clr     = r_clr;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_sz      = r_sz;
        n_ax      = r_ax;
        n_ay      = r_ay;
        n_az      = r_az;
        n_px      = r_px;
        n_y0      = r_y0;
        n_z0      = r_z0;
        n_j       = r_j;
        n_k       = r_k;
        n_acc     = r_acc;
        n_rd_vld  = 1'b0;
        n_rd_row  = w_row;
        n_set     = r_set;
        n_res_st  = r_res_st;
        n_res_x   = r_res_x;
        n_res_y   = r_res_y;
        n_res_z   = r_res_z;
        n_out_vld = r_out_vld && !m_axis_tready;
        n_out_st  = r_out_st;
        n_out_x   = r_out_x;
        n_out_y   = r_out_y;
        n_out_z   = r_out_z;
        occ_we    = 1'b0;
        occ_waddr = r_rd_row;
        occ_wdata = r_set ? (r_occ_q | w_win) : (r_occ_q & ~w_win);
        occ_raddr = w_row;
        rec_we    = 1'b0;
        rec_waddr = {r_z0, r_y0, r_px};
        rec_wdata = '0;
        rec_raddr = {gba3d_pkg::ZW'(w_atz), gba3d_pkg::YW'(w_aty), gba3d_pkg::XW'(w_atx)};

        case (r_state)
            gba3d_pkg::S_CLEAR: begin
                n_clr     = r_clr + 1'b1;
                occ_we    = 1'b1;
                occ_waddr = r_clr[gba3d_pkg::CW-1:gba3d_pkg::XW];
                occ_wdata = '0;
                rec_we    = 1'b1;
                rec_waddr = r_clr;
            end
            gba3d_pkg::S_IDLE: begin
                if (w_acc_in) begin
                    n_sx     = w_sx;
                    n_sy     = w_sy;
                    n_sz     = w_sz;
                    n_ax     = w_cax;
                    n_ay     = w_cay;
                    n_az     = w_caz;
                    n_px     = gba3d_pkg::XW'(w_atx);
                    n_y0     = gba3d_pkg::YW'(w_aty);
                    n_z0     = gba3d_pkg::ZW'(w_atz);
                    n_j      = '0;
                    n_k      = '0;
                    n_acc    = '0;
                    n_res_st = gba3d_pkg::ST_DONE;
                    n_res_x  = '0;
                    n_res_y  = '0;
                    n_res_z  = '0;
                    if (s_axis_tuser == gba3d_pkg::CMD_RELEASE) begin
                        if (w_rel_oor) n_res_st = gba3d_pkg::ST_NOT_REG;
                    end else begin
                        n_y0 = '0;
                        n_z0 = '0;
                        if (w_bad) n_res_st = gba3d_pkg::ST_NO_ROOM;
                    end
                end
            end
            gba3d_pkg::S_ASCAN: begin
                n_rd_vld = 1'b1;
                if (r_rd_vld) n_acc = r_acc | r_occ_q;
                if ({1'b0, r_j} == (gba3d_pkg::YW+1)'(r_sy - 5'd1)) begin
                    n_j = '0;
                    n_k = r_k + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            gba3d_pkg::S_AEVAL: begin
                n_acc = '0;
                n_j   = '0;
                n_k   = '0;
                if (w_found) begin
                    n_px      = w_fx;
                    n_set     = 1'b1;
                    n_res_x   = w_fx;
                    n_res_y   = r_y0;
                    n_res_z   = r_z0;
                    rec_we    = 1'b1;
                    rec_waddr = {r_z0, r_y0, w_fx};
                    rec_wdata = {1'b1, r_sz, r_sy, r_sx};
                end else if (w_y_adv) begin
                    n_y0 = r_y0 + 1'b1;
                end else if (w_z_adv) begin
                    n_y0 = '0;
                    n_z0 = r_z0 + 1'b1;
                end else begin
                    n_res_st = gba3d_pkg::ST_NO_ROOM;
                end
            end
            gba3d_pkg::S_RCHK: begin
                if (r_rec_q[gba3d_pkg::RECW-1]) begin
                    n_sx   = r_rec_q[gba3d_pkg::SXW-1:0];
                    n_sy   = r_rec_q[gba3d_pkg::SXW+gba3d_pkg::SYW-1:gba3d_pkg::SXW];
                    n_sz   = r_rec_q[gba3d_pkg::RECW-2:gba3d_pkg::SXW+gba3d_pkg::SYW];
                    n_set  = 1'b0;
                    rec_we = 1'b1;
                end else begin
                    n_res_st = gba3d_pkg::ST_NOT_REG;
                end
            end
            gba3d_pkg::S_MARK: begin
                // rows are distinct, so the write-back never meets the next read
                n_rd_vld = 1'b1;
                occ_we   = r_rd_vld;
                if ({1'b0, r_j} == (gba3d_pkg::YW+1)'(r_sy - 5'd1)) begin
                    n_j = '0;
                    n_k = r_k + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            gba3d_pkg::S_MFIN: begin
                occ_we = r_rd_vld;
            end
            gba3d_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out_st  = r_res_st;
                    n_out_x   = r_res_x;
                    n_out_y   = r_res_y;
                    n_out_z   = r_res_z;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gba3d_pkg::S_CLEAR;
            r_clr     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_sz     <= n_sz;
        r_ax     <= n_ax;
        r_ay     <= n_ay;
        r_az     <= n_az;
        r_px     <= n_px;
        r_y0     <= n_y0;
        r_z0     <= n_z0;
        r_j      <= n_j;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_rd_row <= n_rd_row;
        r_set    <= n_set;
        r_res_st <= n_res_st;
        r_res_x  <= n_res_x;
        r_res_y  <= n_res_y;
        r_res_z  <= n_res_z;
        r_out_st <= n_out_st;
        r_out_x  <= n_out_x;
        r_out_y  <= n_out_y;
        r_out_z  <= n_out_z;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = 16'({r_out_z, r_out_y, r_out_x});

    // a failed item never reports a place
    a_place_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_st != gba3d_pkg::ST_DONE) |->
        (r_out_x == '0 && r_out_y == '0 && r_out_z == '0))
        else $error("place set on failed result");

    // bitmap is only written while clearing or marking
    a_occ_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_we |-> (r_state == gba3d_pkg::S_CLEAR || r_state == gba3d_pkg::S_MARK ||
                    r_state == gba3d_pkg::S_MFIN))
        else $error("bitmap write outside clear or mark");

    // evaluation and the end of marking always see the last row of the box arriving
    a_eval_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gba3d_pkg::S_AEVAL || r_state == gba3d_pkg::S_MFIN) |-> r_rd_vld)
        else $error("row data missing at end of scan");

    // a finished result never overwrites one not yet taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> (r_out_vld && $stable(r_out_st)))
        else $error("result overwritten");

endmodule
